>>> rtl/srec_pkg.sv
`timescale 1ns / 1ps

package srec_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0]  CSUM_GOOD = 8'hFF;
  localparam int          POS_W     = 10;
  localparam logic [9:0]  POS_MAX   = 10'd1023;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 1;
  localparam logic [0:0] CFG_REQ_HEADER  = 1'd0;
  localparam logic [0:0] CFG_ACCEPT_LOWER = 1'd1;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_S0        = 4'd1,
    ST_S5S6      = 4'd2,
    ST_S7S9      = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_NO_HEADER = 4'd5,
    ST_NOT_S     = 4'd6,
    ST_NONHEX    = 4'd7,
    ST_LOWER     = 4'd8,
    ST_BAD_TYPE  = 4'd9,
    ST_SHORT     = 4'd10,
    ST_SPACE     = 4'd11,
    ST_LONG      = 4'd12,
    ST_CHECKSUM  = 4'd13,
    ST_COUNT_LOW = 4'd14
  } srec_status_t;

  typedef struct packed {
    logic         kind;
    srec_status_t line_status;
    logic [3:0]   record_type;
    logic [31:0]  address;
    logic [7:0]   data_byte;
    logic [7:0]   data_count;
    logic [15:0]  line_number;
    logic         file_error;
    logic         stopped;
  } srec_result_t;

endpackage

>>> rtl/srec_in_if.sv
`timescale 1ns / 1ps

interface srec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

>>> rtl/srec_out_if.sv
`timescale 1ns / 1ps

interface srec_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  line_status;
  logic [3:0]  record_type;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [7:0]  data_count;
  logic [15:0] line_number;
  logic        file_error;
  logic        stopped;

  modport source (output valid, output kind, output line_status, output record_type,
                  output address, output data_byte, output data_count,
                  output line_number, output file_error, output stopped, input ready);
  modport sink   (input valid, input kind, input line_status, input record_type,
                  input address, input data_byte, input data_count,
                  input line_number, input file_error, input stopped, output ready);
endinterface

>>> rtl/srec_in_reg.sv
`timescale 1ns / 1ps

// Input register: captures one character and holds it until the core moves on.
module srec_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  srec_in_if.sink    in_ch,
  input  logic       advance,
  output logic       chr_valid,
  output logic [7:0] chr
);

  logic       valid_r;
  logic [7:0] chr_r;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chr_r <= in_ch.char_in;
    end
  end

  assign chr_valid = valid_r;
  assign chr       = chr_r;

endmodule

>>> rtl/srec_out_reg.sv
`timescale 1ns / 1ps

// Result register: holds one result until the receiver takes it.
module srec_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  srec_pkg::srec_result_t res,
  output logic                  advance,
  srec_out_if.source            out_ch
);

  logic                   valid_r;
  srec_pkg::srec_result_t res_r;

  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.line_status = res_r.line_status;
  assign out_ch.record_type = res_r.record_type;
  assign out_ch.address     = res_r.address;
  assign out_ch.data_byte   = res_r.data_byte;
  assign out_ch.data_count  = res_r.data_count;
  assign out_ch.line_number = res_r.line_number;
  assign out_ch.file_error  = res_r.file_error;
  assign out_ch.stopped     = res_r.stopped;

endmodule

>>> rtl/srec_parse_core.sv
`timescale 1ns / 1ps

// Per-character parse: running line state, configuration and result build.
module srec_parse_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [srec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   fire,
  input  logic [7:0]             chr,
  output logic                   res_valid,
  output srec_pkg::srec_result_t res
);

  logic        req_hdr_r, acc_lower_r;
  logic [9:0]  pos_r, pos_nxt;
  logic [3:0]  td_r, td_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [3:0]  hn_r, hn_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  csum_r, csum_nxt;
  logic [7:0]  doff_r, doff_nxt;
  logic [3:0]  pe_r, pe_nxt;
  logic [15:0] lc_r, lc_nxt;
  logic        fe_r, fe_nxt;
  logic        halted_r, halted_nxt;
  logic        first_s_r, first_s_nxt;
  logic        type_ok_r, type_ok_nxt;
  logic        after_cr_r, after_cr_nxt;

  logic                  is_cr, is_lf, hex, lower;
  logic [3:0]            val;
  logic [15:0]           lc_new;
  logic                  type_ok_new;
  logic [3:0]            td_new;
  logic                  data_new, data_eol;
  logic                  hdr_fault_chr, hdr_fault_eol;
  logic                  skip_check;
  logic [3:0]            pe_new;
  logic [4:0]            abytes;
  logic [9:0]            len_need;
  logic [9:0]            pos_m2;
  logic [8:0]            slot;
  logic [7:0]            byte_val;
  srec_pkg::srec_status_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_hdr_r   <= 1'b1;
      acc_lower_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        srec_pkg::CFG_REQ_HEADER:   req_hdr_r   <= cfg_data;
        srec_pkg::CFG_ACCEPT_LOWER: acc_lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_cr = (chr == srec_pkg::CHAR_CR);
    is_lf = (chr == srec_pkg::CHAR_LF);
    hex   = 1'b0;
    lower = 1'b0;
    val   = 4'd0;
    if (chr >= 8'h30 && chr <= 8'h39) begin
      hex = 1'b1;
      val = chr[3:0];
    end else if (chr >= 8'h41 && chr <= 8'h46) begin
      hex = 1'b1;
      val = chr[3:0] + 4'd9;
    end else if (chr >= 8'h61 && chr <= 8'h66) begin
      hex   = 1'b1;
      lower = 1'b1;
      val   = chr[3:0] + 4'd9;
    end
  end

  always_comb begin
    lc_new = (pos_r == 10'd0 && lc_r != srec_pkg::LINE_MAX) ? lc_r + 16'd1 : lc_r;

    type_ok_new = (pos_r == 10'd1) ? hex : type_ok_r;
    td_new      = (pos_r == 10'd1) ? (hex ? val : 4'd0) : td_r;
    data_new    = type_ok_new && td_new >= 4'd1 && td_new <= 4'd3;
    data_eol    = type_ok_r && td_r >= 4'd1 && td_r <= 4'd3;

    hdr_fault_chr = req_hdr_r && lc_new == 16'd1 && !(type_ok_new && td_new == 4'd0);
    hdr_fault_eol = req_hdr_r && lc_new == 16'd1 && !(type_ok_r && td_r == 4'd0);

    // Record types 7 to 9 skip the character check
    skip_check = type_ok_new && td_new >= 4'd7 && td_new <= 4'd9;
    pe_new     = pe_r;
    if (!skip_check) begin
      if (!hex) begin
        pe_new = srec_pkg::ST_NONHEX;
      end else if (lower && !acc_lower_r) begin
        pe_new = srec_pkg::ST_LOWER;
      end
    end

    abytes   = {1'b0, td_r} + 5'd1;
    len_need = {1'b0, bc_r, 1'b0} + 10'd4;
    pos_m2   = pos_r - 10'd2;
    slot     = pos_m2[9:1];
    byte_val = {hn_r, val};

    // Line-end status in priority order
    st = srec_pkg::ST_OK;
    if (pos_r == 10'd0) begin
      st = srec_pkg::ST_EMPTY;
    end else if (hdr_fault_eol) begin
      st = srec_pkg::ST_NO_HEADER;
    end else if (!first_s_r) begin
      st = srec_pkg::ST_NOT_S;
    end else if (pe_r != 4'd0) begin
      st = srec_pkg::srec_status_t'(pe_r);
    end else if (!type_ok_r) begin
      st = srec_pkg::ST_BAD_TYPE;
    end else if (td_r == 4'd0) begin
      st = srec_pkg::ST_S0;
    end else if (td_r == 4'd5 || td_r == 4'd6) begin
      st = srec_pkg::ST_S5S6;
    end else if (td_r >= 4'd7 && td_r <= 4'd9) begin
      st = srec_pkg::ST_S7S9;
    end else if (td_r > 4'd3) begin
      st = srec_pkg::ST_BAD_TYPE;
    end else if (pos_r < 10'd4 || pos_r < len_need) begin
      st = srec_pkg::ST_SHORT;
    end else if (pos_r > len_need) begin
      st = srec_pkg::ST_LONG;
    end else if ({1'b0, bc_r} < {4'b0, abytes} + 9'd1) begin
      st = srec_pkg::ST_COUNT_LOW;
    end else if (csum_r != srec_pkg::CSUM_GOOD) begin
      st = srec_pkg::ST_CHECKSUM;
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    td_nxt       = td_r;
    bc_nxt       = bc_r;
    hn_nxt       = hn_r;
    addr_nxt     = addr_r;
    csum_nxt     = csum_r;
    doff_nxt     = doff_r;
    pe_nxt       = pe_r;
    lc_nxt       = lc_r;
    fe_nxt       = fe_r;
    halted_nxt   = halted_r;
    first_s_nxt  = first_s_r;
    type_ok_nxt  = type_ok_r;
    after_cr_nxt = after_cr_r;
    res_valid    = 1'b0;
    res          = '0;

    if (fire && !halted_r) begin
      if (after_cr_r && is_lf) begin
        after_cr_nxt = 1'b0;
      end else begin
        after_cr_nxt = is_cr;
        lc_nxt       = lc_new;
        if (is_cr || is_lf) begin
          fe_nxt     = fe_r || (st >= srec_pkg::ST_EMPTY);
          halted_nxt = (st == srec_pkg::ST_EMPTY) || (st == srec_pkg::ST_NO_HEADER);
          res_valid       = 1'b1;
          res.kind        = srec_pkg::KIND_STATUS;
          res.line_status = st;
          res.record_type = td_r;
          res.address     = data_eol ? addr_r : 32'd0;
          res.data_byte   = 8'd0;
          res.data_count  = (st == srec_pkg::ST_OK) ?
                            (bc_r - abytes[7:0] - 8'd1) : 8'd0;
          res.line_number = lc_new;
          res.file_error  = fe_nxt;
          res.stopped     = halted_nxt;
          pos_nxt     = '0;
          td_nxt      = '0;
          bc_nxt      = '0;
          hn_nxt      = '0;
          addr_nxt    = '0;
          csum_nxt    = '0;
          doff_nxt    = '0;
          pe_nxt      = '0;
          first_s_nxt = 1'b0;
          type_ok_nxt = 1'b0;
        end else begin
          if (pos_r == 10'd0) begin
            first_s_nxt = (chr == srec_pkg::CHAR_S);
          end else begin
            type_ok_nxt = type_ok_new;
            td_nxt      = td_new;
            pe_nxt      = pe_new;
            if (pos_r >= 10'd2) begin
              if (!pos_r[0]) begin
                hn_nxt = val;
              end else begin
                csum_nxt = csum_r + byte_val;
                if (slot == 9'd0) begin
                  bc_nxt = byte_val;
                end else if (data_new) begin
                  if (slot <= {4'b0, abytes}) begin
                    addr_nxt = {addr_r[23:0], byte_val};
                  end else if (slot < {1'b0, bc_r}) begin
                    if (first_s_r && !hdr_fault_chr && pe_new == 4'd0) begin
                      res_valid       = 1'b1;
                      res.kind        = srec_pkg::KIND_DATA;
                      res.line_status = srec_pkg::ST_OK;
                      res.record_type = td_new;
                      res.address     = addr_r + {24'd0, doff_r};
                      res.data_byte   = byte_val;
                      res.data_count  = 8'd0;
                      res.line_number = lc_new;
                      res.file_error  = fe_r;
                      res.stopped     = halted_r;
                    end
                    doff_nxt = doff_r + 8'd1;
                  end
                end
              end
            end
          end
          if (pos_r != srec_pkg::POS_MAX) begin
            pos_nxt = pos_r + 10'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      td_r       <= '0;
      bc_r       <= '0;
      hn_r       <= '0;
      addr_r     <= '0;
      csum_r     <= '0;
      doff_r     <= '0;
      pe_r       <= '0;
      lc_r       <= '0;
      fe_r       <= 1'b0;
      halted_r   <= 1'b0;
      first_s_r  <= 1'b0;
      type_ok_r  <= 1'b0;
      after_cr_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      td_r       <= td_nxt;
      bc_r       <= bc_nxt;
      hn_r       <= hn_nxt;
      addr_r     <= addr_nxt;
      csum_r     <= csum_nxt;
      doff_r     <= doff_nxt;
      pe_r       <= pe_nxt;
      lc_r       <= lc_nxt;
      fe_r       <= fe_nxt;
      halted_r   <= halted_nxt;
      first_s_r  <= first_s_nxt;
      type_ok_r  <= type_ok_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

endmodule

>>> rtl/srec_line_parser.sv
`timescale 1ns / 1ps

// S-record line parser.
// The input channel carries one ASCII character per transaction; CR or LF
// ends a line, and an LF straight after a CR belongs to the same line end.
// The result channel carries either a decoded data byte with its own
// address (kind 0) or an end-of-line status report (kind 1). A character
// gives at most one result; many give none.
// A character taken into the input register is held there, is parsed as it
// moves on into the result register, and its result, if any, is then
// offered on the result channel. One character can be taken every
// cycle, since the input register and the result register both move on
// whenever the result register is empty or being emptied.
// If the receiver stalls, the result register holds its transaction, the
// input register fills, and ready on the input side falls until the
// receiver takes the waiting result.
// Reset clears all line state, the line counter and the error and halt
// flags, and sets the configuration to require an S0 header and to reject
// lowercase hex. After an empty line or a missing header the parser halts:
// characters are still taken but ignored until the next reset.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it while the block is idle; the block does not check this.
module srec_line_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                             cfg_data,
  srec_in_if.sink                          in_ch,
  srec_out_if.source                       out_ch
);

  logic                   advance;
  logic                   chr_valid;
  logic [7:0]             chr;
  logic                   res_valid;
  srec_pkg::srec_result_t res;

  // Input register stage
  srec_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .advance   (advance),
    .chr_valid (chr_valid),
    .chr       (chr)
  );

  // The parse happens as the held character moves on to the result stage
  srec_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (chr_valid && advance),
    .chr       (chr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register, emptied by the receiver
  srec_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_ch    (out_ch)
  );

endmodule

>>> test/srec_line_parser_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the S-record line parser.
module srec_line_parser_tb;
  import srec_pkg::*;

  // Quiet cycles allowed before the run is declared hung. The slowest correct
  // stretch is a sender gap plus a receiver stall plus the pipeline.
  localparam int STALL_LIMIT = 1000;
  // Cycles to let a character that gives no result clear the pipeline.
  localparam int HOLD_OFF    = 4;
  localparam int ITEM_TARGET = 1250;
  // One line runs past the saturating character position; it is not counted
  // against the item budget.
  localparam int HUGE_LEN    = 1040;
  localparam int LINES_PER_PHASE = 8;

  // Shapes of generated lines. Most are well-formed records with random
  // content, each error shape damages one aspect of an otherwise good line.
  typedef enum int {
    LN_DATA, LN_HEADER, LN_TERM, LN_OTHER56, LN_BAD_TYPE, LN_NOT_S, LN_NONHEX,
    LN_LOWER, LN_SHORT, LN_LONG, LN_COUNT_LOW, LN_CHECKSUM, LN_NOISE, LN_KINDS
  } line_kind_e;

  // Tracks the parser state character by character and keeps the results
  // that are still owed by the block, oldest first.
  class srec_line_tracker;
    bit                req_header;
    bit                lower_ok;
    logic [9:0]        pos;
    logic [3:0]        type_val;
    logic [7:0]        count_byte;
    logic [3:0]        hi_nib;
    logic [31:0]       addr_acc;
    logic [7:0]        ck_sum;
    logic [7:0]        data_off;
    srec_status_t      char_fault;
    logic [15:0]       line_no;
    bit                any_error;
    bit                is_halted;
    bit                starts_s;
    bit                type_hex;
    bit                cr_seen;
    srec_result_t      owed_results[$];
    int                mismatches;
    int                n_data;
    int                n_reports;
    int                status_hits[16];

    function new();
      req_header = 1'b1;
      lower_ok   = 1'b0;
      line_no    = '0;
      any_error  = 1'b0;
      is_halted  = 1'b0;
      cr_seen    = 1'b0;
      clear_line();
    endfunction

    function void clear_line();
      pos        = '0;
      type_val   = '0;
      count_byte = '0;
      hi_nib     = '0;
      addr_acc   = '0;
      ck_sum     = '0;
      data_off   = '0;
      char_fault = ST_OK;
      starts_s   = 1'b0;
      type_hex   = 1'b0;
    endfunction

    function bit data_record();
      return type_hex && type_val >= 4'd1 && type_val <= 4'd3;
    endfunction

    function bit missing_header();
      return req_header && line_no == 16'd1 && !(type_hex && type_val == 4'd0);
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void owe(logic kind, srec_status_t st, logic [3:0] rtype, logic [31:0] addr,
                      logic [7:0] dbyte, logic [7:0] dcount);
      srec_result_t r;
      r.kind        = kind;
      r.line_status = st;
      r.record_type = rtype;
      r.address     = addr;
      r.data_byte   = dbyte;
      r.data_count  = dcount;
      r.line_number = line_no;
      r.file_error  = any_error;
      r.stopped     = is_halted;
      owed_results.push_back(r);
    endfunction

    // Status report for the line that has just ended, in priority order.
    function void finish_line();
      int           len;
      int           abytes;
      int           full_len;
      srec_status_t st;
      logic [7:0]   dcount;
      len      = pos;
      abytes   = type_val + 1;
      full_len = int'(count_byte) * 2 + 4;
      st       = ST_OK;
      dcount   = '0;
      if (len == 0) st = ST_EMPTY;
      else if (missing_header()) st = ST_NO_HEADER;
      else if (!starts_s) st = ST_NOT_S;
      else if (char_fault != ST_OK) st = char_fault;
      else if (!type_hex) st = ST_BAD_TYPE;
      else if (type_val == 4'd0) st = ST_S0;
      else if (type_val == 4'd5 || type_val == 4'd6) st = ST_S5S6;
      else if (type_val >= 4'd7 && type_val <= 4'd9) st = ST_S7S9;
      else if (type_val > 4'd3) st = ST_BAD_TYPE;
      else if (len < 4 || len < full_len) st = ST_SHORT;
      else if (len > full_len) st = ST_LONG;
      else if (int'(count_byte) < abytes + 1) st = ST_COUNT_LOW;
      else if (ck_sum != CSUM_GOOD) st = ST_CHECKSUM;
      else dcount = count_byte - abytes - 1;
      if (st >= ST_EMPTY) any_error = 1'b1;
      if (st == ST_EMPTY || st == ST_NO_HEADER) is_halted = 1'b1;
      owe(KIND_STATUS, st, type_hex ? type_val : 4'd0, data_record() ? addr_acc : 32'd0,
          8'd0, dcount);
      n_reports++;
      status_hits[st]++;
      clear_line();
    endfunction

    // Called for every character the block accepts.
    function void take_char(logic [7:0] c);
      logic [3:0] nib;
      logic [7:0] bval;
      bit         hex;
      bit         lc;
      int         slot;
      int         abytes;
      if (is_halted) return;
      // An LF straight after a CR is part of the same line end.
      if (cr_seen && c == CHAR_LF) begin
        cr_seen = 1'b0;
        return;
      end
      cr_seen = (c == CHAR_CR);
      if (pos == 0 && line_no != LINE_MAX) line_no++;
      if (c == CHAR_CR || c == CHAR_LF) begin
        finish_line();
        return;
      end
      nib = '0;
      hex = 1'b0;
      lc  = 1'b0;
      if (c >= "0" && c <= "9") begin
        nib = c[3:0];
        hex = 1'b1;
      end else if (c >= "A" && c <= "F") begin
        nib = c[3:0] + 4'd9;
        hex = 1'b1;
      end else if (c >= "a" && c <= "f") begin
        nib = c[3:0] + 4'd9;
        hex = 1'b1;
        lc  = 1'b1;
      end
      if (pos == 0) begin
        starts_s = (c == CHAR_S);
      end else begin
        if (pos == 1) begin
          type_hex = hex;
          type_val = hex ? nib : 4'd0;
        end
        // Termination records are not character-checked at all.
        if (!(type_hex && type_val >= 4'd7 && type_val <= 4'd9)) begin
          if (!hex) char_fault = ST_NONHEX;
          else if (lc && !lower_ok) char_fault = ST_LOWER;
        end
        if (pos >= 2) begin
          if (!pos[0]) begin
            hi_nib = nib;
          end else begin
            bval   = {hi_nib, nib};
            slot   = (int'(pos) - 2) / 2;
            ck_sum = ck_sum + bval;
            if (slot == 0) begin
              count_byte = bval;
            end else if (data_record()) begin
              abytes = type_val + 1;
              if (slot <= abytes) begin
                addr_acc = {addr_acc[23:0], bval};
              end else if (slot < int'(count_byte)) begin
                if (starts_s && !missing_header() && char_fault == ST_OK) begin
                  owe(KIND_DATA, ST_OK, type_val, addr_acc + data_off, bval, 8'd0);
                  n_data++;
                end
                data_off = data_off + 8'd1;
              end
            end
          end
        end
      end
      if (pos != POS_MAX) pos = pos + 10'd1;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(srec_result_t got);
      srec_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d status %0d line %0d",
                 $time, got.kind, got.line_status, got.line_number);
        return;
      end
      want = owed_results.pop_front();
      compare("kind", want.kind, got.kind);
      compare("line_status", want.line_status, got.line_status);
      compare("record_type", want.record_type, got.record_type);
      compare("address", want.address, got.address);
      compare("data_byte", want.data_byte, got.data_byte);
      compare("data_count", want.data_count, got.data_count);
      compare("line_number", want.line_number, got.line_number);
      compare("file_error", want.file_error, got.file_error);
      compare("stopped", want.stopped, got.stopped);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;

  srec_in_if  in_ch();
  srec_out_if out_ch();

  srec_line_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  srec_line_tracker tracker;
  logic [7:0]       line_q[$];
  logic [7:0]       rec_body[$];
  // Idling style per side: 0 never waits, 1 waits now and then, 2 always draws.
  int               in_mode;
  int               out_mode;
  int               sent_chars;
  int               quiet_cycles;

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit lc);
    if (n < 4'd10) return {4'h3, n};
    return (lc ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // Case mode 0 gives uppercase digits, 1 a random mix, 2 lowercase only.
  function automatic void put_byte(logic [7:0] b, int case_mode);
    line_q.push_back(hex_digit(b[7:4], case_mode == 2 || (case_mode == 1 && $urandom_range(0, 1))));
    line_q.push_back(hex_digit(b[3:0], case_mode == 2 || (case_mode == 1 && $urandom_range(0, 1))));
  endfunction

  // Any character but a line end, optionally restricted to non-hex ones.
  function automatic logic [7:0] any_char(bit nonhex);
    logic [7:0] c;
    if (nonhex && $urandom_range(0, 3) == 0) return " ";
    do c = $urandom_range(0, 255);
    while (c == CHAR_CR || c == CHAR_LF ||
           (nonhex && ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                       (c >= "a" && c <= "f"))));
    return c;
  endfunction

  // Address bytes, most significant first, then the data bytes. With top set a
  // four-byte address sits just below the 32-bit ceiling so byte addresses can wrap.
  function automatic void fill_body(int abytes, int ndata, bit top);
    logic [31:0] a;
    rec_body.delete();
    a = $urandom();
    if (top) a[31:8] = '1;
    for (int i = abytes - 1; i >= 0; i--) rec_body.push_back(a[8*i +: 8]);
    repeat (ndata) rec_body.push_back($urandom_range(0, 255));
  endfunction

  // 'S', type, count, body and checksum; skew spoils the checksum when non-zero.
  function automatic void put_record(logic [7:0] type_ch, logic [7:0] skew, int case_mode);
    logic [7:0] cnt;
    logic [7:0] sum;
    cnt = rec_body.size() + 1;
    sum = cnt;
    line_q.push_back(CHAR_S);
    line_q.push_back(type_ch);
    put_byte(cnt, case_mode);
    foreach (rec_body[i]) begin
      put_byte(rec_body[i], case_mode);
      sum = sum + rec_body[i];
    end
    put_byte(~sum + skew, case_mode);
  endfunction

  function automatic void put_data_record(int case_mode, logic [7:0] skew, bit add_letter);
    int k;
    k = $urandom_range(1, 3);
    fill_body(k + 1, ($urandom_range(0, 24) == 0) ? $urandom_range(0, 252 - k)
                                                    : $urandom_range(0, 12),
              $urandom_range(0, 3) == 0);
    if (add_letter) rec_body.push_back(8'hAB);
    put_record(8'h30 + k, skew, case_mode);
  endfunction

  function automatic void build_line(line_kind_e kind);
    string      bad_types;
    logic [7:0] c;
    int         k;
    int         cm;
    bad_types = "4ABCDEF";
    cm = tracker.lower_ok ? $urandom_range(0, 1) : 0;
    case (kind)
      LN_DATA:   put_data_record(cm, 8'd0, 1'b0);
      LN_HEADER: begin
        fill_body(2, $urandom_range(0, 16), 1'b0);
        put_record("0", 8'd0, cm);
      end
      LN_TERM: begin
        // S7/S8/S9 carry 4/3/2 address bytes; stray characters go unchecked.
        k = $urandom_range(7, 9);
        fill_body(11 - k, 0, 1'b0);
        put_record(8'h30 + k, 8'd0, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) line_q[$urandom_range(2, line_q.size() - 1)] = any_char(1'b1);
      end
      LN_OTHER56: begin
        k = $urandom_range(5, 6);
        fill_body(k - 3, 0, 1'b0);
        put_record(8'h30 + k, 8'd0, cm);
      end
      LN_BAD_TYPE: begin
        fill_body(2, $urandom_range(0, 4), 1'b0);
        put_record(($urandom_range(0, 7) == 0) ? any_char(1'b1)
                                               : bad_types[$urandom_range(0, 6)], 8'd0, cm);
      end
      LN_NOT_S: begin
        put_data_record(cm, 8'd0, 1'b0);
        do c = any_char(1'b0);
        while (c == CHAR_S);
        line_q[0] = c;
      end
      LN_NONHEX: begin
        put_data_record(cm, 8'd0, 1'b0);
        line_q[$urandom_range(1, line_q.size() - 1)] = any_char(1'b1);
      end
      LN_LOWER:  put_data_record(2, 8'd0, 1'b1);
      LN_SHORT: begin
        if ($urandom_range(0, 3) == 0) begin
          // Fewer than four characters altogether.
          line_q.push_back(CHAR_S);
          repeat ($urandom_range(0, 2)) line_q.push_back(hex_digit($urandom_range(1, 3), 1'b0));
        end else begin
          put_data_record(cm, 8'd0, 1'b0);
          repeat ($urandom_range(1, 3)) void'(line_q.pop_back());
        end
      end
      LN_LONG: begin
        put_data_record(cm, 8'd0, 1'b0);
        repeat ($urandom_range(1, 3)) line_q.push_back(hex_digit($urandom_range(0, 15), 1'b0));
      end
      LN_COUNT_LOW: begin
        // Count too small to hold the address and the checksum.
        k = $urandom_range(1, 3);
        fill_body($urandom_range(0, k), 0, 1'b0);
        put_record(8'h30 + k, 8'd0, cm);
      end
      LN_CHECKSUM: put_data_record(cm, $urandom_range(1, 255), 1'b0);
      default: repeat ($urandom_range(1, 20)) line_q.push_back(any_char(1'b0));
    endcase
    case ($urandom_range(0, 2))
      0: line_q.push_back(CHAR_CR);
      1: line_q.push_back(CHAR_LF);
      default: begin
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
      end
    endcase
  endfunction

  // Offers one character after a random gap and returns at the edge where the
  // transaction completes, with valid still high.
  task automatic send_char(logic [7:0] c);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk);
    while (!in_ch.ready);
    sent_chars++;
  endtask

  task automatic send_queued_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stops offering characters until every owed result has come back, then
  // lets any trailing character with no result drain out of the pipeline.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk);
    while (tracker.outstanding() != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges while the block is idle.
  task automatic set_config(bit need_header, bit lower_ok);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REQ_HEADER;
    cfg_data  <= need_header;
    @(posedge clk);
    cfg_index <= CFG_ACCEPT_LOWER;
    cfg_data  <= lower_ok;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.req_header = need_header;
    tracker.lower_ok   = lower_ok;
  endtask

  // Every input transaction is handed to the tracker at the edge it completes.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) tracker.take_char(in_ch.char_in);
  end

  // Every output transaction is compared against the oldest owed result.
  always @(posedge clk) begin : result_monitor
    srec_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind        = out_ch.kind;
      got.line_status = srec_status_t'(out_ch.line_status);
      got.record_type = out_ch.record_type;
      got.address     = out_ch.address;
      got.data_byte   = out_ch.data_byte;
      got.data_count  = out_ch.data_count;
      got.line_number = out_ch.line_number;
      got.file_error  = out_ch.file_error;
      got.stopped     = out_ch.stopped;
      tracker.check_result(got);
    end
  end

  // Receiver: draws a stall before each result, then holds ready high until
  // a transaction completes.
  initial begin : result_sink
    int stall;
    forever begin
      stall = draw_gap(out_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!out_ch.valid);
    end
  end

  // Hang detector: any completed transaction on either side restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still owed",
               $time, quiet_cycles, tracker.outstanding());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    line_kind_e   kind;
    int           line_idx;
    int           phase;
    string        hits;
    srec_status_t st;
    tracker       = new();
    quiet_cycles  = 0;
    sent_chars    = 0;
    in_mode       = 0;
    out_mode      = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_REQ_HEADER;
    cfg_data      <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A missing header halts the parser for good and can only arise on line
    // one, so with a single reset the first line is always a proper S0 header
    // and the halting case is taken at the very end with an empty line.
    set_config(1'b1, 1'b0);
    send_text("S0030000FC\r\n");
    // One data byte at 0x0010, terminated by a lone LF.
    send_text("S1040010AA41\n");

    // Random part in phases. Each phase starts from an idle block with a new
    // register setting: the four combinations first, then random ones. The
    // first lines walk through every line shape once so nothing is left to
    // chance, after which good data records make up about half of the lines.
    line_idx = 0;
    phase    = 0;
    while (sent_chars < ITEM_TARGET + HUGE_LEN) begin
      drain();
      case (phase)
        0: set_config(1'b0, 1'b1);
        1: set_config(1'b1, 1'b1);
        2: set_config(1'b0, 1'b0);
        3: set_config(1'b1, 1'b0);
        default: set_config($urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      case (phase)
        0: begin
          in_mode  = 0;
          out_mode = 0;
        end
        1: begin
          in_mode  = 2;
          out_mode = 2;
        end
        default: begin
          in_mode  = $urandom_range(0, 2);
          out_mode = $urandom_range(0, 2);
        end
      endcase
      repeat (LINES_PER_PHASE) begin
        if (line_idx == LN_KINDS + 2) begin
          // A line longer than the character position can count.
          line_q.push_back(CHAR_S);
          line_q.push_back("1");
          repeat (HUGE_LEN) line_q.push_back(hex_digit($urandom_range(0, 15), 1'b0));
          line_q.push_back(CHAR_LF);
        end else begin
          if (line_idx < LN_KINDS) kind = line_kind_e'(line_idx);
          else if ($urandom_range(0, 1) == 0) kind = LN_DATA;
          else kind = line_kind_e'($urandom_range(0, LN_KINDS - 1));
          build_line(kind);
        end
        send_queued_line();
        line_idx++;
      end
      phase++;
    end

    // An empty line halts parsing; whatever follows must be taken and ignored.
    drain();
    in_mode  = 1;
    out_mode = 1;
    send_char(CHAR_CR);
    send_char(8'h00);
    send_char(8'hFF);
    send_text("S1040010AA41\r\n");
    repeat (16) send_char($urandom_range(0, 255));
    drain();
    repeat (8) @(posedge clk);

    hits = "";
    for (int s = 0; s < 16; s++) begin
      if (tracker.status_hits[s] != 0) begin
        st   = srec_status_t'(s);
        hits = {hits, $sformatf(" %s=%0d", st.name(), tracker.status_hits[s])};
      end
    end
    $display("Run covered %0d characters over %0d register phases: %0d data bytes, %0d reports.",
             sent_chars, phase, tracker.n_data, tracker.n_reports);
    $display("Line reports by status:%s", hits);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
